[hdl/pibe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibe_pkg
// Shared types and fixed constants of the peak interval tempo estimator.
// ----------------------------------------------------------------------------
package pibe_pkg;

   // Field widths fixed by the stream format
   localparam int SAMPLE_W   = 16;
   localparam int THRESH_W   = 15;
   localparam int GAP_W      = 20;
   localparam int RATE_W     = 18;
   localparam int BPM_W      = 16;
   localparam int OUT_CNT_W  = 24;
   localparam int SINCE_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Rate times sixty fits in 24 bits for every 18-bit rate
   localparam int RATE60_W   = 24;
   localparam int FRAC_BITS  = 8;
   localparam int Q_WIDTH    = 16;
   localparam int Q_CNT_W    = $clog2(Q_WIDTH);

   localparam logic [5:0]  SEC_PER_MIN = 6'd60;
   localparam logic [7:0]  BPM_LO      = 8'd60;
   localparam logic [7:0]  BPM_HI      = 8'd200;
   localparam logic [BPM_W-1:0] FALLBACK_Q8 = 16'd30720;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd22938;
   localparam logic [GAP_W-1:0]    GAP_RESET    = 20'd8820;
   localparam logic [RATE_W-1:0]   RATE_RESET   = 18'd44100;

   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE    = 2'd2;

   typedef struct packed {
      logic take;
      logic mul_rate;
      logic mul_n;
      logic check;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic fb_now;
   } status_type;

endpackage

[hdl/pibe_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibe_if
// Sample stream and tempo result stream channels.
// ----------------------------------------------------------------------------
interface pibe_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pibe_pkg::SAMPLE_W-1:0] sample;
   logic                                 last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface pibe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pibe_pkg::BPM_W-1:0]        bpm_q8;
   logic                              fallback;
   logic [pibe_pkg::OUT_CNT_W-1:0]    interval_total;

   modport source (output valid, output bpm_q8, output fallback, output interval_total,
                   input ready);
   modport sink   (input valid, input bpm_q8, input fallback, input interval_total,
                   output ready);
endinterface

[hdl/pibe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibe_ctrl
// Sequencer: takes items, runs the tempo calculation after the last item of a
// track and owns the result valid flag.
// ----------------------------------------------------------------------------
module pibe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pibe_pkg::status_type status,
   output pibe_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MULR  = 3'd1;
   localparam logic [2:0] ST_MULN  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                  st_ff, st_in;
   logic [pibe_pkg::Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        req_fire;

   assign req_ready = (st_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (st_ff)
         ST_IDLE: begin
            cmd.take = req_fire;
            if (req_fire && req_last) begin
               st_in = ST_MULR;
            end
         end
         ST_MULR: begin
            cmd.mul_rate = 1'b1;
            st_in        = ST_MULN;
         end
         ST_MULN: begin
            cmd.mul_n = 1'b1;
            st_in     = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.fb_now) begin
               st_in = ST_DONE;
            end else begin
               cnt_in = pibe_pkg::Q_CNT_W'(pibe_pkg::Q_WIDTH - 1);
               st_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               st_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_last_starts_calc: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> st_ff == ST_MULR)
      else $error("last item did not start the tempo calculation");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result valid raised without a finished calculation");

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_DIV |-> cnt_ff == '0)
      else $error("divide step counter left running");

endmodule

[hdl/pibe_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibe_dpath
// Peak tracking, interval sum and count, config registers, tempo multiply
// and a restoring divider that yields one quotient bit per step.
// ----------------------------------------------------------------------------
module pibe_dpath #(
   parameter int SUM_WIDTH   = 32,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pibe_pkg::cmd_type                     cmd,
   output pibe_pkg::status_type                  status,
   input  logic                                  csr_we,
   input  logic [pibe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pibe_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [pibe_pkg::SAMPLE_W-1:0]         sample,
   output logic [pibe_pkg::BPM_W-1:0]            bpm_q8,
   output logic                                  fallback,
   output logic [pibe_pkg::OUT_CNT_W-1:0]        interval_total
);

   localparam int SW   = SUM_WIDTH;
   localparam int CW   = COUNT_WIDTH;
   localparam int SPW  = pibe_pkg::SINCE_W;
   localparam int SXW  = ((SW > SPW) ? SW : SPW) + 1;
   localparam int NW   = pibe_pkg::RATE60_W + CW;
   localparam int CMPW = (NW > SW + 8) ? NW : SW + 8;
   localparam int DW   = ((NW + pibe_pkg::FRAC_BITS > SW) ? NW + pibe_pkg::FRAC_BITS : SW) + 1;
   localparam int QW   = pibe_pkg::Q_WIDTH;
   localparam int CWX  = (CW > pibe_pkg::OUT_CNT_W) ? CW : pibe_pkg::OUT_CNT_W;

   logic [pibe_pkg::THRESH_W-1:0] thresh_ff;
   logic [pibe_pkg::GAP_W-1:0]    gap_ff;
   logic [pibe_pkg::RATE_W-1:0]   rate_ff;

   logic [SPW-1:0] since_ff, since_in;
   logic           have_ff, have_in;
   logic           past_ff, past_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [CW-1:0]  count_ff, count_in;

   logic [pibe_pkg::RATE60_W-1:0] r60_ff;
   logic [NW-1:0]                 n_ff;
   logic [CMPW-1:0]               s60_ff, s200_ff;
   logic                          fb_ff;
   logic [SW-1:0]                 rem_ff;
   logic [QW-1:0]                 dlo_ff;

   logic [pibe_pkg::BPM_W-1:0]     bpm_ff;
   logic                           fb_out_ff;
   logic [pibe_pkg::OUT_CNT_W-1:0] total_ff;

   logic [pibe_pkg::SAMPLE_W-1:0] mag;
   logic [SPW-1:0]                span;
   logic                          spaced, is_peak;
   logic [SXW-1:0]                sum_ext;
   logic [DW-1:0]                 dividend;
   logic [SW:0]                   trial;
   logic                          trial_ge;
   logic [CWX-1:0]                count_wide;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= pibe_pkg::THRESH_RESET;
         gap_ff    <= pibe_pkg::GAP_RESET;
         rate_ff   <= pibe_pkg::RATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pibe_pkg::CSR_PEAK_THRESHOLD: thresh_ff <= csr_wdata[pibe_pkg::THRESH_W-1:0];
            pibe_pkg::CSR_MIN_GAP:        gap_ff    <= csr_wdata[pibe_pkg::GAP_W-1:0];
            pibe_pkg::CSR_SAMPLE_RATE:    rate_ff   <= csr_wdata[pibe_pkg::RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // peak detection on the incoming item
   always_comb begin
      mag      = sample[pibe_pkg::SAMPLE_W-1] ? (pibe_pkg::SAMPLE_W'(0) - sample) : sample;
      span     = (since_ff == '1) ? since_ff : since_ff + 1'b1;
      spaced   = have_ff ? (span > SPW'(gap_ff)) : past_ff;
      is_peak  = (mag > pibe_pkg::SAMPLE_W'(thresh_ff)) && spaced;
      sum_ext  = SXW'(sum_ff) + SXW'(span);

      since_in = since_ff;
      have_in  = have_ff;
      past_in  = past_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.take) begin
         past_in = 1'b1;
         if (is_peak) begin
            if (have_ff) begin
               sum_in = (sum_ext > SXW'({SW{1'b1}})) ? {SW{1'b1}} : sum_ext[SW-1:0];
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
            end
            have_in  = 1'b1;
            since_in = '0;
         end else begin
            since_in = span;
         end
      end else if (cmd.finish) begin
         since_in = '0;
         have_in  = 1'b0;
         past_in  = 1'b0;
         sum_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= '0;
         have_ff  <= 1'b0;
         past_ff  <= 1'b0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         since_ff <= since_in;
         have_ff  <= have_in;
         past_ff  <= past_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // tempo calculation: N = 60*rate*count, q = floor((256*N + sum/2) / sum)
   assign status.fb_now = (count_ff == '0) || (sum_ff == '0)
                          || (CMPW'(n_ff) < s60_ff) || (CMPW'(n_ff) > s200_ff);

   assign dividend = DW'({n_ff, pibe_pkg::FRAC_BITS'(0)}) + DW'(sum_ff >> 1);
   assign trial    = {rem_ff, dlo_ff[QW-1]};
   assign trial_ge = trial >= {1'b0, sum_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul_rate) begin
         r60_ff <= pibe_pkg::RATE60_W'(rate_ff) * pibe_pkg::RATE60_W'(pibe_pkg::SEC_PER_MIN);
      end
      if (cmd.mul_n) begin
         n_ff    <= NW'(r60_ff) * NW'(count_ff);
         s60_ff  <= CMPW'(sum_ff) * CMPW'(pibe_pkg::BPM_LO);
         s200_ff <= CMPW'(sum_ff) * CMPW'(pibe_pkg::BPM_HI);
      end
      if (cmd.check) begin
         fb_ff  <= status.fb_now;
         // quotient fits in QW bits, so the upper part is already below sum
         rem_ff <= SW'(dividend >> QW);
         dlo_ff <= dividend[QW-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? SW'(trial - {1'b0, sum_ff}) : trial[SW-1:0];
         dlo_ff <= {dlo_ff[QW-2:0], trial_ge};
      end
   end

   // result register
   assign count_wide = CWX'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         bpm_ff    <= fb_ff ? pibe_pkg::FALLBACK_Q8 : pibe_pkg::BPM_W'(dlo_ff);
         fb_out_ff <= fb_ff;
         total_ff  <= (count_wide > CWX'({pibe_pkg::OUT_CNT_W{1'b1}}))
                      ? {pibe_pkg::OUT_CNT_W{1'b1}} : count_wide[pibe_pkg::OUT_CNT_W-1:0];
      end
   end

   assign bpm_q8         = bpm_ff;
   assign fallback       = fb_out_ff;
   assign interval_total = total_ff;

endmodule

[hdl/peak_interval_bpm_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_interval_bpm_estimator
// Estimates track tempo from the spacing of loud peaks in an audio stream.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        sample (Q1.15), last
//   rsp      out  valid/ready        bpm_q8 (Q8.8), fallback, interval_total
//   csr      in   csr_we             csr_index, csr_wdata
//
// A new item without last is taken every cycle while no calculation runs.
// An item with last starts the tempo calculation: two multiply stages, a
// range check and 16 restoring divide steps, then the result register
// loads (the divide steps are skipped on fallback); req_ready is low meanwhile.
// A result still waiting on rsp does not stop items; only the next result
// load waits for it. Synchronous reset restores register defaults and
// clears the track state.
// ----------------------------------------------------------------------------
module peak_interval_bpm_estimator #(
   parameter int SUM_WIDTH   = 32,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   pibe_req_if.sink                        req,
   pibe_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [pibe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pibe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pibe_pkg::cmd_type    cmd;
   pibe_pkg::status_type status;
   logic                 req_ready;
   logic                 rsp_valid;

   pibe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pibe_dpath #(
      .SUM_WIDTH   (SUM_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .sample         (req.sample),
      .bpm_q8         (rsp.bpm_q8),
      .fallback       (rsp.fallback),
      .interval_total (rsp.interval_total)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

endmodule
